FILE: sv/pts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

  // Store and cell sizing
  localparam int MAX_DEGREE = 7;
  localparam int NUM_CELLS  = MAX_DEGREE + 1;
  localparam int IDX_W      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int CNT_W      = $clog2(NUM_CELLS + 1);

  // Field widths
  localparam int DATA_W     = 64;
  localparam int HALF_W     = DATA_W / 2;
  localparam int DEG_W      = 3;
  localparam int OIDX_W     = 3;
  localparam int CFG_IDX_W  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_DEGREE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT = CFG_IDX_W'(1);

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLR,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_UPD,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  // Sequencer status towards the top level
  typedef struct packed {
    logic             busy;
    logic             out_valid;
    logic             out_last;
    logic             done;
    logic [IDX_W-1:0] out_idx;
    logic [IDX_W-1:0] step;
  } seq_stat_t;

endpackage

`default_nettype wire

FILE: sv/pts_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One coefficient of the running Horner polynomial q(x).
// A step multiplies q by (x - r): q[i] becomes q[i-1] - r * q[i].
module pts_cell import pts_pkg::*; (
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] shift_amt,
  input  wire logic [DATA_W-1:0] lower_q,
  input  wire logic [DATA_W-1:0] upper_q,
  output logic      [DATA_W-1:0] q
);

  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [DATA_W-1:0] prod;

  // Operand select for the 32x32 multiplier: low*low, low*high, high*low
  always_comb begin
    unique case (ctrl.op)
      OP_MUL1: begin
        mul_a = q_r[HALF_W-1:0];
        mul_b = shift_amt[DATA_W-1:HALF_W];
      end
      OP_MUL2: begin
        mul_a = q_r[DATA_W-1:HALF_W];
        mul_b = shift_amt[HALF_W-1:0];
      end
      default: begin
        mul_a = q_r[HALF_W-1:0];
        mul_b = shift_amt[HALF_W-1:0];
      end
    endcase
  end

  assign prod = DATA_W'(mul_a) * DATA_W'(mul_b);

  // Next state of the coefficient and the product accumulator
  always_comb begin
    q_nxt   = q_r;
    acc_nxt = acc_r;
    unique case (ctrl.op)
      OP_NOP:   ;
      OP_CLR:   q_nxt = '0;
      OP_MUL0:  acc_nxt = prod;
      OP_MUL1,
      OP_MUL2:  acc_nxt = acc_r + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      OP_UPD:   q_nxt = lower_q - acc_r;
      OP_SHIFT: q_nxt = upper_q;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

FILE: sv/pts_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: clears the cells, runs deg+1 Horner steps (MUL0, MUL1, MUL2,
// UPD) from the top coefficient down, then shifts the results out of cell 0.
module pts_seq import pts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [IDX_W-1:0] deg_in,
  output cell_ctrl_t            ctrl,
  output seq_stat_t             stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_UPD,
    S_OUT
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] step_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      idx_r   <= '0;
      deg_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            deg_r   <= deg_in;
            step_r  <= deg_in;
            state_r <= S_CLEAR;
          end
        end
        S_CLEAR: state_r <= S_MUL0;
        S_MUL0:  state_r <= S_MUL1;
        S_MUL1:  state_r <= S_MUL2;
        S_MUL2:  state_r <= S_UPD;
        S_UPD: begin
          if (step_r == '0) begin
            idx_r   <= '0;
            state_r <= S_OUT;
          end else begin
            step_r  <= step_r - IDX_W'(1);
            state_r <= S_MUL0;
          end
        end
        S_OUT: begin
          if (idx_r == deg_r) begin
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Cell operation decode
  always_comb begin
    unique case (state_r)
      S_CLEAR: ctrl.op = OP_CLR;
      S_MUL0:  ctrl.op = OP_MUL0;
      S_MUL1:  ctrl.op = OP_MUL1;
      S_MUL2:  ctrl.op = OP_MUL2;
      S_UPD:   ctrl.op = OP_UPD;
      S_OUT:   ctrl.op = OP_SHIFT;
      default: ctrl.op = OP_NOP;
    endcase
  end

  assign stat.busy      = (state_r != S_IDLE);
  assign stat.out_valid = (state_r == S_OUT);
  assign stat.out_last  = (state_r == S_OUT) && (idx_r == deg_r);
  assign stat.done      = (state_r == S_OUT) && (idx_r == deg_r);
  assign stat.out_idx   = idx_r;
  assign stat.step      = step_r;

endmodule

`default_nettype wire

FILE: sv/poly_taylor_shift_mod64.sv
`timescale 1ns / 1ps
`default_nettype none

// Taylor shift q(x) = p(x - r), all arithmetic modulo 2^64.
// Input: coefficients lowest order first, one per transaction, taken at an
// edge with start high and busy low; in_coeff_last closes the polynomial.
// Extra coefficients past the store depth drop.
// Configuration: cfg_wr_en with cfg_index 0 (degree) or 1 (shift r), only
// while busy is low; other indexes are ignored.
// After the last coefficient the block is busy: a clear step, then deg+1
// Horner steps of MUL0, MUL1, MUL2 and UPD, each cell's 32x32 multiplier
// taking three passes per 64-bit product. Then deg+1 results follow on
// consecutive cycles, lowest order first, out_result_last on the top one.
// Each result is on the out_ ports for one cycle with out_strobe; the
// receiver cannot stall. Reset clears the configuration and the fill count;
// the coefficient store needs no clearing since the count masks it.
module poly_taylor_shift_mod64 import pts_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [DATA_W-1:0]    in_coeff_value,
  input  wire logic                 in_coeff_last,
  output logic                      out_strobe,
  output logic      [DATA_W-1:0]    out_shifted_coeff,
  output logic      [OIDX_W-1:0]    out_coeff_index,
  output logic                      out_result_last,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_wr_data
);

  logic [DEG_W-1:0]  poly_degree_r;
  logic [DATA_W-1:0] shift_amount_r;
  logic [CNT_W-1:0]  count_r;
  logic [DATA_W-1:0] coeff_store_r [NUM_CELLS];

  logic              accept;
  logic              store_wr;
  logic [IDX_W-1:0]  deg_eff;
  logic [DATA_W-1:0] feed;
  logic [DATA_W-1:0] q_w [NUM_CELLS];
  cell_ctrl_t        ctrl;
  seq_stat_t         stat;

  assign accept   = start && !stat.busy;
  assign store_wr = accept && (count_r < CNT_W'(NUM_CELLS));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_degree_r  <= '0;
      shift_amount_r <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_POLY_DEGREE) begin
        poly_degree_r <= cfg_wr_data[DEG_W-1:0];
      end else if (cfg_index == CFG_SHIFT_AMOUNT) begin
        shift_amount_r <= cfg_wr_data;
      end
    end
  end

  // Fill count, saturating at the store depth and cleared on the last result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (stat.done) begin
      count_r <= '0;
    end else if (store_wr) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Coefficient store; entries at or above the count read as zero
  always_ff @(posedge clk) begin
    if (store_wr) begin
      coeff_store_r[count_r[IDX_W-1:0]] <= in_coeff_value;
    end
  end

  assign deg_eff = (int'(poly_degree_r) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE)
                                                      : IDX_W'(poly_degree_r);

  assign feed = (CNT_W'(stat.step) < count_r) ? coeff_store_r[stat.step] : '0;

  pts_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (accept && in_coeff_last),
    .deg_in (deg_eff),
    .ctrl   (ctrl),
    .stat   (stat)
  );

  // Row of cells; cell 0 takes the next coefficient, the top one sees zero
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (g == 0) begin : g_lo
      assign lower = feed;
    end else begin : g_lo
      assign lower = q_w[g-1];
    end
    if (g == NUM_CELLS - 1) begin : g_hi
      assign upper = '0;
    end else begin : g_hi
      assign upper = q_w[g+1];
    end
    pts_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .shift_amt (shift_amount_r),
      .lower_q   (lower),
      .upper_q   (upper),
      .q         (q_w[g])
    );
  end

  assign busy              = stat.busy;
  assign out_strobe        = stat.out_valid;
  assign out_shifted_coeff = q_w[0];
  assign out_coeff_index   = OIDX_W'(stat.out_idx);
  assign out_result_last   = stat.out_last;

`ifndef SYNTH
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe outside a computation");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_coeff_last) |=> (busy && !out_strobe))
    else $error("closing coefficient did not start a computation");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_result_last) |=>
      (out_strobe && out_coeff_index == $past(out_coeff_index) + OIDX_W'(1)))
    else $error("result indexes not consecutive");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result_last) |=> (!out_strobe && !busy))
    else $error("results continue after the top coefficient");
`endif

endmodule

`default_nettype wire
